FILE: hdl/clt_pkg.sv
// Shared types, codes and helpers for the command line tokenizer.
`default_nettype none

package clt_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned TOTAL_W = 5;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned NAME_W  = 64;
    localparam int unsigned NLEN_W  = 4;
    localparam int unsigned NAME_MAX = 8;

    // configuration register indexes
    localparam logic [1:0] CFG_NAME_CHARS  = 2'd0;
    localparam logic [1:0] CFG_NAME_LENGTH = 2'd1;

    // result kinds
    localparam logic [KIND_W-1:0] K_BYTE   = 3'd0;
    localparam logic [KIND_W-1:0] K_END    = 3'd1;
    localparam logic [KIND_W-1:0] K_NAME   = 3'd2;
    localparam logic [KIND_W-1:0] K_ACCEPT = 3'd3;
    localparam logic [KIND_W-1:0] K_REJECT = 3'd4;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;

    typedef enum logic [6:0] {
        PH_LEAD   = 7'b0000001,
        PH_NAME   = 7'b0000010,
        PH_GAP    = 7'b0000100,
        PH_ARG    = 7'b0001000,
        PH_QUOTE  = 7'b0010000,
        PH_DRAIN  = 7'b0100000,
        PH_IGNORE = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TOTAL_W-1:0] arg_total;
        logic [IDX_W-1:0]   arg_index;
        logic [CHAR_W-1:0]  byte_out;
    } t_result;

    // results caused by one input byte
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_step;

    function automatic t_result make_res(
        input logic [KIND_W-1:0]  kind,
        input logic [CHAR_W-1:0]  b,
        input logic [IDX_W-1:0]   idx,
        input logic [TOTAL_W-1:0] total
    );
        t_result r;
        r.kind      = kind;
        r.byte_out  = b;
        r.arg_index = idx;
        r.arg_total = total;
        return r;
    endfunction

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

`default_nettype wire

FILE: hdl/clt_fsm.sv
// Tokenizer state machine: line phase, name match, argument count.
`default_nettype none

module clt_fsm #(
    parameter int unsigned MAX_ARGS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic [clt_pkg::CHAR_W-1:0]   i_char,
    input  wire logic [clt_pkg::NAME_W-1:0]   i_name_chars,
    input  wire logic [clt_pkg::NLEN_W-1:0]   i_name_length,
    output clt_pkg::t_step                    o_step
);

    clt_pkg::t_phase              r_phase, n_phase;
    logic [clt_pkg::POS_W-1:0]    r_pos, n_pos;
    logic                         r_qd, n_qd;
    logic [clt_pkg::TOTAL_W-1:0]  r_cnt, n_cnt;

    logic [clt_pkg::POS_W-1:0]    lim;
    logic [clt_pkg::POS_W-1:0]    len;
    logic [clt_pkg::CHAR_W-1:0]   want;
    logic [clt_pkg::IDX_W-1:0]    cur;
    logic [clt_pkg::IDX_W-1:0]    nxt_idx;
    logic [clt_pkg::TOTAL_W-1:0]  cnt_inc;
    logic                         blank;
    logic                         is_quote;
    logic                         skip;
    clt_pkg::t_phase              ph;
    logic [clt_pkg::POS_W-1:0]    pos;
    clt_pkg::t_step               step;

    // effective name length: saturate at 8, stop at the first zero byte
    always_comb begin
        lim = (i_name_length > clt_pkg::POS_W'(clt_pkg::NAME_MAX))
            ? clt_pkg::POS_W'(clt_pkg::NAME_MAX) : i_name_length;
        len = lim;
        for (int i = clt_pkg::NAME_MAX - 1; i >= 0; i--) begin
            if ((clt_pkg::POS_W'(i) < lim) && (i_name_chars[i*8 +: 8] == clt_pkg::CH_NUL)) begin
                len = clt_pkg::POS_W'(i);
            end
        end
    end

    assign blank    = clt_pkg::is_blank(i_char);
    assign is_quote = (i_char == clt_pkg::CH_SQUOTE) || (i_char == clt_pkg::CH_DQUOTE);
    assign cur      = r_cnt[clt_pkg::IDX_W-1:0] - clt_pkg::IDX_W'(1);
    assign cnt_inc  = r_cnt + clt_pkg::TOTAL_W'(1);
    assign nxt_idx  = r_cnt[clt_pkg::IDX_W-1:0];

    always_comb begin
        ph   = r_phase;
        pos  = r_pos;
        skip = 1'b0;
        if (r_phase == clt_pkg::PH_LEAD) begin
            if (len == '0) begin
                ph = clt_pkg::PH_GAP;
            end else if (blank) begin
                skip = 1'b1;
            end else begin
                ph  = clt_pkg::PH_NAME;
                pos = '0;
            end
        end
        want = i_name_chars[{pos[2:0], 3'b000} +: 8];
    end

    always_comb begin
        n_phase = ph;
        n_pos   = pos;
        n_qd    = r_qd;
        n_cnt   = r_cnt;
        step    = '0;
        if (!skip) begin
            unique case (ph)
                clt_pkg::PH_NAME: begin
                    if (pos < len) begin
                        if (i_char == clt_pkg::CH_NUL) begin
                            step.count = 2'd1;
                            step.r0 = clt_pkg::make_res(clt_pkg::K_REJECT, '0, '0, '0);
                            n_phase = clt_pkg::PH_LEAD;
                            n_pos   = '0;
                            n_qd    = 1'b0;
                            n_cnt   = '0;
                        end else if (i_char == want) begin
                            n_pos = pos + clt_pkg::POS_W'(1);
                        end else begin
                            n_phase = clt_pkg::PH_DRAIN;
                        end
                    end else if (i_char == clt_pkg::CH_NUL) begin
                        step.count = 2'd2;
                        step.r0 = clt_pkg::make_res(clt_pkg::K_NAME, '0, '0, '0);
                        step.r1 = clt_pkg::make_res(clt_pkg::K_ACCEPT, '0, '0,
                                                    clt_pkg::TOTAL_W'(1));
                        n_phase = clt_pkg::PH_LEAD;
                        n_pos   = '0;
                        n_qd    = 1'b0;
                        n_cnt   = '0;
                    end else if (blank) begin
                        step.count = 2'd1;
                        step.r0 = clt_pkg::make_res(clt_pkg::K_NAME, '0, '0, '0);
                        n_cnt   = clt_pkg::TOTAL_W'(1);
                        n_phase = clt_pkg::PH_GAP;
                    end else begin
                        n_phase = clt_pkg::PH_DRAIN;
                    end
                end
                clt_pkg::PH_GAP: begin
                    if (i_char == clt_pkg::CH_NUL) begin
                        step.count = 2'd1;
                        if (r_cnt != '0) begin
                            step.r0 = clt_pkg::make_res(clt_pkg::K_ACCEPT, '0, '0, r_cnt);
                        end else begin
                            step.r0 = clt_pkg::make_res(clt_pkg::K_REJECT, '0, '0, '0);
                        end
                        n_phase = clt_pkg::PH_LEAD;
                        n_pos   = '0;
                        n_qd    = 1'b0;
                        n_cnt   = '0;
                    end else if (blank) begin
                        n_phase = clt_pkg::PH_GAP;
                    end else if (r_cnt >= clt_pkg::TOTAL_W'(MAX_ARGS)) begin
                        n_phase = clt_pkg::PH_IGNORE;
                    end else begin
                        n_cnt = cnt_inc;
                        if (is_quote) begin
                            n_qd    = (i_char == clt_pkg::CH_DQUOTE);
                            n_phase = clt_pkg::PH_QUOTE;
                        end else begin
                            step.count = 2'd1;
                            step.r0 = clt_pkg::make_res(clt_pkg::K_BYTE, i_char, nxt_idx, '0);
                            n_phase = clt_pkg::PH_ARG;
                        end
                    end
                end
                clt_pkg::PH_ARG: begin
                    if (i_char == clt_pkg::CH_NUL) begin
                        step.count = 2'd2;
                        step.r0 = clt_pkg::make_res(clt_pkg::K_END, '0, cur, '0);
                        step.r1 = clt_pkg::make_res(clt_pkg::K_ACCEPT, '0, '0, r_cnt);
                        n_phase = clt_pkg::PH_LEAD;
                        n_pos   = '0;
                        n_qd    = 1'b0;
                        n_cnt   = '0;
                    end else if (blank) begin
                        step.count = 2'd1;
                        step.r0 = clt_pkg::make_res(clt_pkg::K_END, '0, cur, '0);
                        n_phase = clt_pkg::PH_GAP;
                    end else if (is_quote) begin
                        n_qd    = (i_char == clt_pkg::CH_DQUOTE);
                        n_phase = clt_pkg::PH_QUOTE;
                    end else begin
                        step.count = 2'd1;
                        step.r0 = clt_pkg::make_res(clt_pkg::K_BYTE, i_char, cur, '0);
                    end
                end
                clt_pkg::PH_QUOTE: begin
                    if (i_char == clt_pkg::CH_NUL) begin
                        // unclosed quote still closes the argument
                        step.count = 2'd2;
                        step.r0 = clt_pkg::make_res(clt_pkg::K_END, '0, cur, '0);
                        step.r1 = clt_pkg::make_res(clt_pkg::K_ACCEPT, '0, '0, r_cnt);
                        n_phase = clt_pkg::PH_LEAD;
                        n_pos   = '0;
                        n_qd    = 1'b0;
                        n_cnt   = '0;
                    end else if (i_char == (r_qd ? clt_pkg::CH_DQUOTE : clt_pkg::CH_SQUOTE)) begin
                        n_phase = clt_pkg::PH_ARG;
                    end else begin
                        step.count = 2'd1;
                        step.r0 = clt_pkg::make_res(clt_pkg::K_BYTE, i_char, cur, '0);
                    end
                end
                clt_pkg::PH_IGNORE: begin
                    if (i_char == clt_pkg::CH_NUL) begin
                        step.count = 2'd1;
                        step.r0 = clt_pkg::make_res(clt_pkg::K_ACCEPT, '0, '0, r_cnt);
                        n_phase = clt_pkg::PH_LEAD;
                        n_pos   = '0;
                        n_qd    = 1'b0;
                        n_cnt   = '0;
                    end
                end
                default: begin
                    // drain after a name mismatch
                    if (i_char == clt_pkg::CH_NUL) begin
                        step.count = 2'd1;
                        step.r0 = clt_pkg::make_res(clt_pkg::K_REJECT, '0, '0, '0);
                        n_phase = clt_pkg::PH_LEAD;
                        n_pos   = '0;
                        n_qd    = 1'b0;
                        n_cnt   = '0;
                    end else begin
                        n_phase = clt_pkg::PH_DRAIN;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= clt_pkg::PH_LEAD;
            r_pos   <= '0;
            r_qd    <= 1'b0;
            r_cnt   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_qd    <= n_qd;
            r_cnt   <= n_cnt;
        end
    end

    assign o_step = step;

endmodule

`default_nettype wire

FILE: hdl/command_line_tokenizer_unit.sv
// Top level of the command line tokenizer: config registers, state machine, result queue.
//
//  channel   dir  handshake                     payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata: char_in
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: byte_out, arg_index, arg_total
//                                                  tuser: kind
//  cfg       in   i_cfg_valid/o_cfg_ready          i_cfg_index, i_cfg_data
//
// One byte is taken per cycle; its results go into a 4-entry result queue in the same edge
// and reach m_axis behind earlier results. A byte yields at most two results, so s_axis
// is ready while the queue holds two or fewer. Output drains one result per cycle while
// m_axis is ready. Synchronous active-low reset clears the line state, config registers
// and queue. Config writes are always taken.
`default_nettype none

module command_line_tokenizer_unit #(
    parameter int unsigned MAX_ARGS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] char_in
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,   // [7:0] byte_out, [11:8] arg_index,
                                               // [16:12] arg_total, [23:17] zero
    output logic [2:0]       o_m_axis_tuser,   // [2:0] kind
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    localparam int unsigned QDEPTH = 4;

    logic [clt_pkg::NAME_W-1:0] r_name_chars;
    logic [clt_pkg::NLEN_W-1:0] r_name_length;

    clt_pkg::t_result r_q [QDEPTH];
    clt_pkg::t_result n_q [QDEPTH];
    clt_pkg::t_result shifted [QDEPTH];
    logic [2:0]       r_cnt, n_cnt;
    logic [2:0]       base;
    logic [1:0]       push;
    logic             pop;
    logic             in_acc;
    clt_pkg::t_step   step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_chars  <= '0;
            r_name_length <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == clt_pkg::CFG_NAME_CHARS) begin
                r_name_chars <= i_cfg_data;
            end else if (i_cfg_index == clt_pkg::CFG_NAME_LENGTH) begin
                r_name_length <= i_cfg_data[clt_pkg::NLEN_W-1:0];
            end
        end
    end

    assign o_s_axis_tready = (r_cnt <= 3'd2);
    assign in_acc          = i_s_axis_tvalid & o_s_axis_tready;

    clt_fsm #(
        .MAX_ARGS (MAX_ARGS)
    ) u_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_acc),
        .i_char        (i_s_axis_tdata),
        .i_name_chars  (r_name_chars),
        .i_name_length (r_name_length),
        .o_step        (step)
    );

    assign o_m_axis_tvalid = (r_cnt != '0);
    assign pop             = o_m_axis_tvalid & i_m_axis_tready;
    assign push            = in_acc ? step.count : 2'd0;
    assign base            = r_cnt - {2'b00, pop};

    always_comb begin
        for (int i = 0; i < QDEPTH - 1; i++) begin
            shifted[i] = pop ? r_q[i+1] : r_q[i];
        end
        shifted[QDEPTH-1] = r_q[QDEPTH-1];
        for (int i = 0; i < QDEPTH; i++) begin
            n_q[i] = shifted[i];
            if ((3'(i) == base) && (push != 2'd0)) begin
                n_q[i] = step.r0;
            end
            if ((3'(i) == base + 3'd1) && (push == 2'd2)) begin
                n_q[i] = step.r1;
            end
        end
        n_cnt = base + {1'b0, push};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    assign o_m_axis_tdata = {7'b0, r_q[0].arg_total, r_q[0].arg_index, r_q[0].byte_out};
    assign o_m_axis_tuser = r_q[0].kind;

    // queue never overflows
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("result queue overflow");

    // a line terminator always leaves at least one result queued
    a_eol_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_axis_tdata == clt_pkg::CH_NUL) |=> (r_cnt != '0))
        else $error("line end produced no result");

    // presented kind is a defined code
    a_kind_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser <= clt_pkg::K_REJECT))
        else $error("undefined result kind");

endmodule

`default_nettype wire
